// File: src/oldest_request_queue_per_session_unit_defines.svh
// Assertion macros used by the request table controller.
`ifndef OLDEST_REQUEST_QUEUE_PER_SESSION_UNIT_DEFINES_SVH
`define OLDEST_REQUEST_QUEUE_PER_SESSION_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ORQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ORQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/orq_pkg.sv
package orq_pkg;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_EVICT   = 2'd2;

    localparam logic [2:0] OUT_DELIVERED = 3'd0;
    localparam logic [2:0] OUT_NONE      = 3'd1;
    localparam logic [2:0] OUT_EXPIRED   = 3'd2;
    localparam logic [2:0] OUT_EVICTED   = 3'd3;
    localparam logic [2:0] OUT_INSERTED  = 3'd4;
    localparam logic [2:0] OUT_FULL      = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] session;
        logic [63:0] enq_time;
        logic [31:0] timeout;
        logic [31:0] handle;
        logic [31:0] ident;
    } t_entry;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
    } t_store_ctl;

endpackage

// File: src/orq_store.sv
module orq_store #(
    parameter int TABLE_DEPTH = 16,
    parameter int AW          = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  orq_pkg::t_store_ctl i_ctl,
    input  logic [AW-1:0]       i_rd_addr,
    input  logic [AW-1:0]       i_wr_addr,
    input  orq_pkg::t_entry     i_wr_data,
    output orq_pkg::t_entry     o_rd_data,
    output logic                o_rd_used
);
    import orq_pkg::*;

    t_entry                  r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]  r_used;
    t_entry                  r_rd_data;
    logic                    r_rd_used;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_used <= r_used[i_rd_addr];
        end
    end

    // Occupancy bits sit in flip-flops so that reset empties the table at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_ctl.wr_en) begin
            r_used[i_wr_addr] <= 1'b1;
        end else if (i_ctl.clr_en) begin
            r_used[i_wr_addr] <= 1'b0;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_used = r_rd_used;

endmodule

// File: src/orq_ctrl.sv
`include "oldest_request_queue_per_session_unit_defines.svh"

module orq_ctrl #(
    parameter int TABLE_DEPTH = 16,
    parameter int AW          = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_op,
    input  logic [31:0]         i_session_key,
    input  logic [63:0]         i_now_time,
    input  logic [31:0]         i_timeout_limit,
    input  logic [31:0]         i_handle_in,
    input  logic [31:0]         i_ident_in,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [2:0]          o_outcome,
    output logic [31:0]         o_handle,
    output logic [31:0]         o_ident,
    output orq_pkg::t_store_ctl o_st_ctl,
    output logic [AW-1:0]       o_rd_addr,
    output logic [AW-1:0]       o_wr_addr,
    output orq_pkg::t_entry     o_wr_data,
    input  orq_pkg::t_entry     i_rd_data,
    input  logic                i_rd_used
);
    import orq_pkg::*;

    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_idx;
    logic          r_cmp_vld;
    logic [AW-1:0] r_cmp_idx;

    logic [1:0]    r_op;
    logic [31:0]   r_key;
    logic [63:0]   r_now;
    logic [31:0]   r_tmo;
    logic [31:0]   r_handle;
    logic [31:0]   r_ident;

    logic          r_found;
    logic [AW-1:0] r_best_idx;
    logic [63:0]   r_best_time;
    logic [31:0]   r_best_tmo;
    logic [31:0]   r_best_handle;
    logic [31:0]   r_best_ident;
    logic          r_free_found;
    logic [AW-1:0] r_free_idx;

    logic          in_xfer;
    logic          res_xfer;
    logic          cmp_hit;
    logic          cmp_take;
    logic          free_take;
    logic [64:0]   age;
    logic          expired;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign res_xfer = o_res_valid && i_res_ready;

    // Oldest match wins; a strict compare keeps the lowest slot on equal times.
    assign cmp_hit   = r_cmp_vld && i_rd_used && (i_rd_data.session == r_key);
    assign cmp_take  = cmp_hit && (!r_found || (i_rd_data.enq_time < r_best_time));
    assign free_take = r_cmp_vld && !i_rd_used && !r_free_found;

    // The borrow of the subtraction tells whether the clock is behind the enqueue time.
    assign age     = {1'b0, r_now} - {1'b0, r_best_time};
    assign expired = (r_best_tmo != '0) && !age[64] && (age[63:0] > {32'd0, r_best_tmo});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE);
        o_res_valid    = (r_state == ST_DONE);
        o_rd_addr      = r_idx;
        o_st_ctl.rd_en = (r_state == ST_SCAN);
        o_st_ctl.wr_en = res_xfer && (r_op == OP_INSERT) && r_free_found;
        o_st_ctl.clr_en = res_xfer && r_found && ((r_op == OP_DEQUEUE) || (r_op == OP_EVICT));
        o_wr_addr      = (r_op == OP_INSERT) ? r_free_idx : r_best_idx;
        o_wr_data.session  = r_key;
        o_wr_data.enq_time = r_now;
        o_wr_data.timeout  = r_tmo;
        o_wr_data.handle   = r_handle;
        o_wr_data.ident    = r_ident;

        o_outcome = OUT_NONE;
        o_handle  = '0;
        o_ident   = '0;
        unique case (r_op)
            OP_INSERT: begin
                o_outcome = r_free_found ? OUT_INSERTED : OUT_FULL;
            end
            OP_DEQUEUE: begin
                if (r_found) begin
                    o_outcome = expired ? OUT_EXPIRED : OUT_DELIVERED;
                    o_handle  = r_best_handle;
                    o_ident   = r_best_ident;
                end
            end
            OP_EVICT: begin
                if (r_found) begin
                    o_outcome = OUT_EVICTED;
                    o_handle  = r_best_handle;
                    o_ident   = r_best_ident;
                end
            end
            default: begin
                o_outcome = OUT_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN);
            if (in_xfer) begin
                r_idx        <= '0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (r_state == ST_SCAN) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (cmp_take) begin
                    r_found <= 1'b1;
                end
                if (free_take) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op     <= i_op;
            r_key    <= i_session_key;
            r_now    <= i_now_time;
            r_tmo    <= i_timeout_limit;
            r_handle <= i_handle_in;
            r_ident  <= i_ident_in;
        end
        r_cmp_idx <= r_idx;
        if (cmp_take) begin
            r_best_idx    <= r_cmp_idx;
            r_best_time   <= i_rd_data.enq_time;
            r_best_tmo    <= i_rd_data.timeout;
            r_best_handle <= i_rd_data.handle;
            r_best_ident  <= i_rd_data.ident;
        end
        if (free_take) begin
            r_free_idx <= r_cmp_idx;
        end
    end

    `ORQ_ASSERT_SAME(a_write_only_on_insert, o_st_ctl.wr_en, (r_op == OP_INSERT) && r_free_found && (r_state == ST_DONE), "table written outside a successful insert")
    `ORQ_ASSERT_NEXT(a_accept_starts_scan, in_xfer, (r_state == ST_SCAN) && (r_idx == '0) && !r_found && !r_free_found, "scan did not restart after accepting an item")
    `ORQ_ASSERT_NEXT(a_result_ends_item, res_xfer, (r_state == ST_IDLE) && !r_cmp_vld, "block not idle after handing over a result")
    `ORQ_ASSERT_SAME(a_compare_in_scan, r_cmp_vld, (r_state == ST_SCAN) || (r_state == ST_DRAIN), "compare stage active outside the scan")

endmodule

// File: src/oldest_request_queue_per_session_unit.sv
// Per-session request table with oldest-first removal. An item is accepted
// only while the block is idle; it then reads every slot of the entry memory
// in turn through its single read port, one slot per cycle, tracking the
// oldest entry of the session and the lowest free slot. After the scan and
// a drain state for the last compare, the result waits in the done state
// until the output register takes it. The next item is taken in the cycle
// after the result leaves the controller, so a new item is not accepted
// before the last one is finished. The output register holds a finished
// result while the next item is already being scanned. Reset clears every
// occupancy bit of the table.
module oldest_request_queue_per_session_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_session_key,
    input  logic [63:0] i_now_time,
    input  logic [31:0] i_timeout_limit,
    input  logic [31:0] i_handle_in,
    input  logic [31:0] i_ident_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_outcome,
    output logic [31:0] o_handle_out,
    output logic [31:0] o_ident_out
);
    import orq_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    t_store_ctl    st_ctl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        rd_data;
    logic          rd_used;

    logic          res_valid;
    logic          res_ready;
    logic [2:0]    res_outcome;
    logic [31:0]   res_handle;
    logic [31:0]   res_ident;

    logic          r_out_valid;
    logic [2:0]    r_outcome;
    logic [31:0]   r_handle;
    logic [31:0]   r_ident;

    orq_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_session_key   (i_session_key),
        .i_now_time      (i_now_time),
        .i_timeout_limit (i_timeout_limit),
        .i_handle_in     (i_handle_in),
        .i_ident_in      (i_ident_in),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_outcome       (res_outcome),
        .o_handle        (res_handle),
        .o_ident         (res_ident),
        .o_st_ctl        (st_ctl),
        .o_rd_addr       (rd_addr),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .i_rd_data       (rd_data),
        .i_rd_used       (rd_used)
    );

    orq_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (st_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data),
        .o_rd_used (rd_used)
    );

    // The output register takes a new result when empty or being emptied.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_outcome <= res_outcome;
            r_handle  <= res_handle;
            r_ident   <= res_ident;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_outcome    = r_outcome;
    assign o_handle_out = r_handle;
    assign o_ident_out  = r_ident;

endmodule
